/* rtl/keyed_priority_queue_update_assert.svh */
// Assertion macros for the keyed priority queue RTL
`ifndef KEYED_PRIORITY_QUEUE_UPDATE_ASSERT_SVH
`define KEYED_PRIORITY_QUEUE_UPDATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define KPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kpq assertion failed");
`define KPQ_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define KPQ_ASSERT(lbl, clk, rstn, prop)
`define KPQ_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`endif
`endif

/* rtl/kpq_pkg.sv */
// ---------------------------------------------------------------------------
// kpq_pkg
// Types, codes and helpers shared by the keyed priority queue modules.
// ---------------------------------------------------------------------------
package kpq_pkg;

  typedef enum logic [1:0] {
    OP_ADMIT  = 2'd0,
    OP_CHANGE = 2'd1,
    OP_POP    = 2'd2,
    OP_QUERY  = 2'd3
  } kpq_op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NOTFOUND = 3'd1,
    STAT_DUP      = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_BADSEV   = 3'd4
  } kpq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } kpq_state_e;

  localparam int unsigned KeyW = 41;

  typedef struct packed {
    kpq_op_e     operation;
    logic [15:0] patient_id;
    logic [1:0]  severity;
    logic [15:0] arrival_time;
    logic [6:0]  age;
    logic [4:0]  doctor_count;
    logic [15:0] current_time;
  } kpq_in_t;

  typedef struct packed {
    kpq_status_e status;
    logic        served_valid;
    logic [15:0] served_id;
    logic [4:0]  served_count;
    logic [31:0] wait_total;
    logic [15:0] wait_entries;
    logic        last;
  } kpq_out_t;

  // classified command, as queued between front and back
  typedef struct packed {
    kpq_in_t    item;
    logic       bad_sev;
    logic [4:0] limit;
  } kpq_cmd_t;

  // handshake between front queue and back sequencer
  typedef struct packed {
    logic     valid;
    kpq_cmd_t cmd;
  } kpq_q_t;

  // stored table entry
  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  sev;
    logic [15:0] arr;
    logic [6:0]  age;
    logic [15:0] adm;
  } kpq_entry_t;

  // ordering key, lower is served first
  function automatic logic [KeyW-1:0] kpq_key(kpq_entry_t e);
    return {e.sev, e.arr, 7'h7f - e.age, e.id};
  endfunction

endpackage

/* rtl/kpq_front.sv */
// ---------------------------------------------------------------------------
// kpq_front
// Accepts items, flags bad severities, clips the pop limit and queues them.
// ---------------------------------------------------------------------------
module kpq_front #(
  parameter int MAX_SERVE = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  kpq_pkg::kpq_in_t cmd_i,
  output kpq_pkg::kpq_q_t  q_o,
  input  logic           pop_i
);
  import kpq_pkg::*;

  kpq_cmd_t   buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  kpq_cmd_t   cls;

  // classify
  always_comb begin
    cls.item    = cmd_i;
    cls.bad_sev = (cmd_i.operation != OP_POP) && (cmd_i.severity == 2'd0);
    if (32'(cmd_i.doctor_count) < MAX_SERVE) begin
      cls.limit = cmd_i.doctor_count;
    end else begin
      cls.limit = 5'(MAX_SERVE);
    end
  end

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cls;
    end
  end

  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.cmd   = buf_q[rd_q];

endmodule

/* rtl/kpq_back.sv */
// ---------------------------------------------------------------------------
// kpq_back
// Executes queued items: slot scans over the table memory and result output.
// ---------------------------------------------------------------------------
`include "keyed_priority_queue_update_assert.svh"
module kpq_back #(
  parameter int CAPACITY = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kpq_pkg::kpq_q_t q_i,
  output logic            pop_o,
  output logic            res_valid_o,
  output kpq_pkg::kpq_out_t res_o
);
  import kpq_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  kpq_entry_t mem [CAPACITY];
  kpq_entry_t rdata_q;

  kpq_state_e      state_q, state_d;
  kpq_cmd_t        cmd_q, cmd_d;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CW-1:0]   occ_q, occ_d;
  logic [CW-1:0]   ridx_q, ridx_d;
  logic            cv_q, cv_d;
  logic [IW-1:0]   cidx_q, cidx_d;
  logic            hit_q, hit_d;
  logic [IW-1:0]   hidx_q, hidx_d;
  kpq_entry_t      hent_q, hent_d;
  logic            free_q, free_d;
  logic [IW-1:0]   fidx_q, fidx_d;
  logic [4:0]      n_q, n_d;
  logic [31:0]     sum_q [3];
  logic [31:0]     sum_d [3];
  logic [15:0]     cnt_q [3];
  logic [15:0]     cnt_d [3];
  logic            res_valid_q, res_valid_d;
  kpq_out_t        res_d, res_q;
  logic            we;
  logic [IW-1:0]   waddr;
  kpq_entry_t      wdata;
  logic            rd_en;

  logic [15:0]     wait_v;
  logic [32:0]     sum_ext;
  logic [1:0]      lvl;
  logic [4:0]      n_nx;
  kpq_out_t        blank;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    valid_d     = valid_q;
    occ_d       = occ_q;
    ridx_d      = ridx_q;
    cv_d        = 1'b0;
    cidx_d      = cidx_q;
    hit_d       = hit_q;
    hidx_d      = hidx_q;
    hent_d      = hent_q;
    free_d      = free_q;
    fidx_d      = fidx_q;
    n_d         = n_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    blank       = '0;
    blank.status = STAT_OK;
    blank.last   = 1'b1;
    res_d       = blank;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = hidx_q;
    wdata       = hent_q;
    rd_en       = 1'b0;
    lvl         = hent_q.sev - 2'd1;
    wait_v      = cmd_q.item.current_time - hent_q.adm;
    sum_ext     = {1'b0, sum_q[lvl]} + {17'd0, wait_v};
    n_nx        = n_q + 5'd1;

    unique case (state_q)
      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o  = 1'b1;
          cmd_d  = q_i.cmd;
          ridx_d = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          n_d    = '0;
          if (q_i.cmd.bad_sev) begin
            res_valid_d  = 1'b1;
            res_d.status = STAT_BADSEV;
          end else if (q_i.cmd.item.operation == OP_QUERY) begin
            res_valid_d        = 1'b1;
            res_d.wait_total   = sum_q[q_i.cmd.item.severity - 2'd1];
            res_d.wait_entries = cnt_q[q_i.cmd.item.severity - 2'd1];
          end else if (q_i.cmd.item.operation == OP_POP &&
                       (q_i.cmd.limit == 5'd0 || occ_q == '0)) begin
            res_valid_d = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle
        if (ridx_q != CW'(CAPACITY)) begin
          rd_en  = 1'b1;
          cv_d   = 1'b1;
          cidx_d = ridx_q[IW-1:0];
          ridx_d = ridx_q + CW'(1);
        end
        // evaluate the slot read last cycle
        if (cv_q) begin
          if (cmd_q.item.operation == OP_POP) begin
            if (valid_q[cidx_q] &&
                (!hit_q || kpq_key(rdata_q) < kpq_key(hent_q))) begin
              hit_d  = 1'b1;
              hidx_d = cidx_q;
              hent_d = rdata_q;
            end
          end else begin
            if (valid_q[cidx_q] && rdata_q.id == cmd_q.item.patient_id) begin
              hit_d  = 1'b1;
              hidx_d = cidx_q;
              hent_d = rdata_q;
            end
            if (!valid_q[cidx_q] && !free_q) begin
              free_d = 1'b1;
              fidx_d = cidx_q;
            end
          end
        end else if (ridx_q == CW'(CAPACITY)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_valid_d = 1'b1;
        state_d     = ST_IDLE;
        case (cmd_q.item.operation)
          OP_ADMIT: begin
            if (hit_q) begin
              res_d.status = STAT_DUP;
            end else if (occ_q == CW'(CAPACITY)) begin
              res_d.status = STAT_FULL;
            end else begin
              we        = 1'b1;
              waddr     = fidx_q;
              wdata.id  = cmd_q.item.patient_id;
              wdata.sev = cmd_q.item.severity;
              wdata.arr = cmd_q.item.arrival_time;
              wdata.age = cmd_q.item.age;
              wdata.adm = cmd_q.item.current_time;
              valid_d[fidx_q] = 1'b1;
              occ_d     = occ_q + CW'(1);
            end
          end
          OP_CHANGE: begin
            if (!hit_q) begin
              res_d.status = STAT_NOTFOUND;
            end else begin
              we        = 1'b1;
              wdata.sev = cmd_q.item.severity;
            end
          end
          default: begin
            // pop: serve best slot, account its wait
            sum_d[lvl] = sum_ext[32] ? 32'hffff_ffff : sum_ext[31:0];
            if (cnt_q[lvl] != 16'hffff) begin
              cnt_d[lvl] = cnt_q[lvl] + 16'd1;
            end
            valid_d[hidx_q]    = 1'b0;
            occ_d              = occ_q - CW'(1);
            n_d                = n_nx;
            res_d.served_valid = 1'b1;
            res_d.served_id    = hent_q.id;
            res_d.served_count = n_nx;
            res_d.last = (n_nx == cmd_q.limit) || (occ_q == CW'(1));
            if (!res_d.last) begin
              state_d = ST_SCAN;
              ridx_d  = '0;
              hit_d   = 1'b0;
            end
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      occ_q       <= '0;
      cv_q        <= 1'b0;
      res_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
        cnt_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      cv_q        <= cv_d;
      res_valid_q <= res_valid_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ridx_q <= ridx_d;
    cidx_q <= cidx_d;
    hit_q  <= hit_d;
    hidx_q <= hidx_d;
    hent_q <= hent_d;
    free_q <= free_d;
    fidx_q <= fidx_d;
    n_q    <= n_d;
    res_q  <= res_d;
  end

  // slot table memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[ridx_q[IW-1:0]];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `KPQ_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= CW'(CAPACITY))
  `KPQ_ASSERT_MSG(a_occ_track, clk_i, rst_ni,
    occ_q == CW'($countones(valid_q)), "occupancy out of step with valid bits")
  `KPQ_ASSERT(a_pop_idle, clk_i, rst_ni, pop_o |-> state_q == ST_IDLE)
  `KPQ_ASSERT(a_served_cnt, clk_i, rst_ni,
    (res_valid_o && res_o.served_valid) |-> res_o.served_count != 5'd0)

endmodule

/* rtl/keyed_priority_queue_update.sv */
// Error and query items are answered from idle; admit and change do a full slot scan.
// Pop: one full slot scan per served entry.
// Throughput is set by the single read port of the slot table memory.
// A two-entry command queue takes items while the back end scans.
// Reset (asynchronous, active low) empties the table and clears the wait totals.
// Results are a one-cycle strobe; the receiver cannot stall them.
// ---------------------------------------------------------------------------
// keyed_priority_queue_update
// Keyed priority table with severity update, pop of best entries and wait totals.
// ---------------------------------------------------------------------------
module keyed_priority_queue_update #(
  parameter int CAPACITY  = 64,
  parameter int MAX_SERVE = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  kpq_pkg::kpq_in_t   cmd_i,
  output logic               res_valid_o,
  output kpq_pkg::kpq_out_t  res_o
);
  import kpq_pkg::*;

  kpq_q_t q;
  logic   pop;

  kpq_front #(.MAX_SERVE(MAX_SERVE)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .q_o    (q),
    .pop_i  (pop)
  );

  kpq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
